[design/ssr_pkg.sv]
`timescale 1ns / 1ps

package ssr_pkg;

   // Field widths shared by the channel interfaces and the datapath.
   localparam int SUBPIXEL_W = 8;
   localparam int COORD_W    = 10;
   localparam int COLOR_W    = 16;

   // Divide by three as a multiply by a reciprocal: floor(s * 683 / 2048)
   // equals floor(s / 3) for every sum of three 8-bit values.
   localparam logic [9:0] RECIP3       = 10'd683;
   localparam int         RECIP3_SHIFT = 11;

   // Phase of pixel assembly: which smoothed value the next one will be.
   localparam logic [1:0] PHASE_RED   = 2'd0;
   localparam logic [1:0] PHASE_GREEN = 2'd1;
   localparam logic [1:0] PHASE_BLUE  = 2'd2;

   // Item count within a row, saturating once the filters are fully primed.
   localparam logic [1:0] POS_FIRST  = 2'd0;
   localparam logic [1:0] POS_SECOND = 2'd1;
   localparam logic [1:0] POS_THIRD  = 2'd2;
   localparam logic [1:0] POS_FULL   = 2'd3;

   // Truncated mean of three 8-bit samples.
   function automatic logic [SUBPIXEL_W-1:0] avg3(input logic [SUBPIXEL_W-1:0] a,
                                                  input logic [SUBPIXEL_W-1:0] b,
                                                  input logic [SUBPIXEL_W-1:0] c);
      logic [9:0]  sum;
      logic [19:0] prod;
      sum  = {2'b00, a} + {2'b00, b} + {2'b00, c};
      prod = {10'd0, sum} * {10'd0, RECIP3};
      return prod[RECIP3_SHIFT +: SUBPIXEL_W];
   endfunction

endpackage

[design/ssr_if.sv]
`timescale 1ns / 1ps

// Request channel: one sub-pixel of a row.
interface ssr_req_if;
   logic                             valid;
   logic                             ready;
   logic [ssr_pkg::SUBPIXEL_W-1:0]   subpixel;
   logic [ssr_pkg::COORD_W-1:0]      row_x;
   logic [ssr_pkg::COORD_W-1:0]      row_y;
   logic                             row_last;

   modport source (output valid, subpixel, row_x, row_y, row_last, input ready);
   modport sink (input valid, subpixel, row_x, row_y, row_last, output ready);
endinterface

// Result channel: one packed RGB565 pixel.
interface ssr_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [ssr_pkg::COORD_W-1:0]      pix_x;
   logic [ssr_pkg::COORD_W-1:0]      pix_y;
   logic [ssr_pkg::COLOR_W-1:0]      color565;
   logic                             pix_last;

   modport source (output valid, pix_x, pix_y, color565, pix_last, input ready);
   modport sink (input valid, pix_x, pix_y, color565, pix_last, output ready);
endinterface

[design/subpixel_smooth_rgb565.sv]
`timescale 1ns / 1ps
// A request is first registered in the input register; its pixel (if any) is then
// loaded into the result register once that is free. Throughput: one request per
// cycle; the only limit is the single result register, when a pixel waits in it.
// Reset (synchronous, active high) clears both valid flags, the filter histories,
// the row position, the assembly phase, the held colors and the cursor.
module subpixel_smooth_rgb565 (
   input  logic       clock,
   input  logic       reset,
   ssr_req_if.sink    req_bus,
   ssr_rsp_if.source  rsp_bus
);

   localparam int SW = ssr_pkg::SUBPIXEL_W;
   localparam int CW = ssr_pkg::COORD_W;

   // Input register.
   logic          in_valid_ff;
   logic [SW-1:0] in_sub_ff;
   logic [CW-1:0] in_x_ff;
   logic [CW-1:0] in_y_ff;
   logic          in_last_ff;

   // Filter and assembly state.
   logic [SW-1:0] raw1_ff, raw2_ff, raw1_in, raw2_in;
   logic [SW-1:0] st1_ff, st2_ff, st1_in, st2_in;
   logic [1:0]    pos_ff, pos_in;
   logic [1:0]    phase_ff, phase_in;
   logic [SW-1:0] held_r_ff, held_g_ff, held_r_in, held_g_in;
   logic [CW-1:0] cur_x_ff, cur_y_ff, cur_x_in, cur_y_in;

   // Result register.
   logic                         out_valid_ff;
   logic [CW-1:0]                out_x_ff, out_y_ff;
   logic [ssr_pkg::COLOR_W-1:0]  out_color_ff, color_in;
   logic                         out_last_ff;

   logic          advance;
   logic          emit;
   logic [CW-1:0] base_x, base_y;
   logic [SW-1:0] s_a, s_b, q1, q2, v1, v2, v3;
   logic [SW-1:0] vals [3];
   logic          vld  [3];

   assign advance       = in_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || advance;

   // Accept a request into the input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         in_valid_ff <= req_bus.valid;
      end
      if (req_bus.ready && req_bus.valid) begin
         in_sub_ff  <= req_bus.subpixel;
         in_x_ff    <= req_bus.row_x;
         in_y_ff    <= req_bus.row_y;
         in_last_ff <= req_bus.row_last;
      end
   end

   // Both box filters: the interior tap from the regular step and, on the last
   // item of a row, the flush with the edge sample replicated.
   always_comb begin
      s_a = ssr_pkg::avg3((pos_ff == ssr_pkg::POS_SECOND) ? raw1_ff : raw2_ff,
                          raw1_ff, in_sub_ff);
      s_b = (pos_ff == ssr_pkg::POS_FIRST) ? in_sub_ff
                                           : ssr_pkg::avg3(raw1_ff, in_sub_ff, in_sub_ff);
      // Second filter history as seen by the flush step.
      q1  = (pos_ff != ssr_pkg::POS_FIRST) ? s_a : st1_ff;
      q2  = (pos_ff != ssr_pkg::POS_FIRST) ? st1_ff : st2_ff;
      v1  = ssr_pkg::avg3((pos_ff == ssr_pkg::POS_THIRD) ? st1_ff : st2_ff, st1_ff, s_a);
      v2  = ssr_pkg::avg3((pos_ff == ssr_pkg::POS_SECOND) ? q1 : q2, q1, s_b);
      v3  = (pos_ff == ssr_pkg::POS_FIRST) ? s_b : ssr_pkg::avg3(q1, s_b, s_b);

      vals[0] = v1;
      vals[1] = v2;
      vals[2] = v3;
      vld[0]  = pos_ff[1];
      vld[1]  = in_last_ff && (pos_ff != ssr_pkg::POS_FIRST);
      vld[2]  = in_last_ff;
   end

   // Filter history and row position.
   always_comb begin
      raw1_in = in_sub_ff;
      raw2_in = raw1_ff;
      if (in_last_ff) begin
         st1_in = s_b;
         st2_in = q1;
      end else if (pos_ff != ssr_pkg::POS_FIRST) begin
         st1_in = s_a;
         st2_in = st1_ff;
      end else begin
         st1_in = st1_ff;
         st2_in = st2_ff;
      end
      if (in_last_ff) begin
         pos_in = ssr_pkg::POS_FIRST;
      end else if (pos_ff != ssr_pkg::POS_FULL) begin
         pos_in = pos_ff + 2'd1;
      end else begin
         pos_in = pos_ff;
      end
   end

   // Pixel assembly over up to three smoothed values in this item.
   always_comb begin
      logic [1:0] ph;
      ph        = phase_ff;
      held_r_in = held_r_ff;
      held_g_in = held_g_ff;
      emit      = 1'b0;
      color_in  = '0;
      for (int i = 0; i < 3; i++) begin
         if (vld[i]) begin
            case (ph)
               ssr_pkg::PHASE_GREEN: begin
                  held_g_in = vals[i];
                  ph        = ssr_pkg::PHASE_BLUE;
               end
               ssr_pkg::PHASE_BLUE: begin
                  color_in = {held_r_in[SW-1:3], held_g_in[SW-1:2], vals[i][SW-1:3]};
                  emit     = 1'b1;
                  ph       = ssr_pkg::PHASE_RED;
               end
               default: begin
                  held_r_in = vals[i];
                  ph        = ssr_pkg::PHASE_GREEN;
               end
            endcase
         end
      end
      phase_in = in_last_ff ? ssr_pkg::PHASE_RED : ph;
   end

   // Cursor: loaded from the first item of a row, stepped per emitted pixel.
   always_comb begin
      base_x   = (pos_ff == ssr_pkg::POS_FIRST) ? in_x_ff : cur_x_ff;
      base_y   = (pos_ff == ssr_pkg::POS_FIRST) ? in_y_ff : cur_y_ff;
      cur_x_in = base_x + {{(CW-1){1'b0}}, emit};
      cur_y_in = base_y;
   end

   // State update when the registered request is consumed.
   always_ff @(posedge clock) begin
      if (reset) begin
         raw1_ff   <= '0;
         raw2_ff   <= '0;
         st1_ff    <= '0;
         st2_ff    <= '0;
         pos_ff    <= ssr_pkg::POS_FIRST;
         phase_ff  <= ssr_pkg::PHASE_RED;
         held_r_ff <= '0;
         held_g_ff <= '0;
         cur_x_ff  <= '0;
         cur_y_ff  <= '0;
      end else if (advance) begin
         raw1_ff   <= raw1_in;
         raw2_ff   <= raw2_in;
         st1_ff    <= st1_in;
         st2_ff    <= st2_in;
         pos_ff    <= pos_in;
         phase_ff  <= phase_in;
         held_r_ff <= held_r_in;
         held_g_ff <= held_g_in;
         cur_x_ff  <= cur_x_in;
         cur_y_ff  <= cur_y_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= emit;
      end else if (rsp_bus.ready) begin
         out_valid_ff <= 1'b0;
      end
      if (advance && emit) begin
         out_x_ff     <= base_x;
         out_y_ff     <= base_y;
         out_color_ff <= color_in;
         out_last_ff  <= in_last_ff;
      end
   end

   assign rsp_bus.valid    = out_valid_ff;
   assign rsp_bus.pix_x    = out_x_ff;
   assign rsp_bus.pix_y    = out_y_ff;
   assign rsp_bus.color565 = out_color_ff;
   assign rsp_bus.pix_last = out_last_ff;

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

   localparam int ITEM_TARGET  = 1750;
   localparam int DRAIN_POINT  = 1200;
   localparam int CHOKE_POINT  = 600;
   localparam int CHOKE_CYCLES = 300;
   localparam int STALL_LIMIT  = 3000;
   localparam int DRAIN_CYCLES = 20;
   localparam int REPORT_CAP   = 60;

   localparam int SUB_W   = ssr_pkg::SUBPIXEL_W;
   localparam int COORD_W = ssr_pkg::COORD_W;
   localparam int COLOR_W = ssr_pkg::COLOR_W;

   // How a request's pixel is checked: by the predictor, typed as none, or typed in.
   typedef enum logic [1:0] {
      CHECK_MODEL,
      CHECK_NONE,
      CHECK_PIXEL
   } check_kind_type;

   typedef struct packed {
      logic [COORD_W-1:0] pix_x;
      logic [COORD_W-1:0] pix_y;
      logic [COLOR_W-1:0] color565;
      logic               pix_last;
   } pixel_type;

   typedef struct packed {
      logic [SUB_W-1:0]   subpixel;
      logic [COORD_W-1:0] row_x;
      logic [COORD_W-1:0] row_y;
      logic               row_last;
      check_kind_type     kind;
      pixel_type          pix;
   } stim_type;

   logic clock;
   logic reset;

   ssr_req_if req_bus ();
   ssr_rsp_if rsp_bus ();

   subpixel_smooth_rgb565 i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // Predictor state: filter histories, row progress, pixel assembly and cursor.
   logic [SUB_W-1:0]   raw_h0, raw_h1;
   logic [SUB_W-1:0]   smooth_h0, smooth_h1;
   int                 row_pos;
   logic [1:0]         phase;
   logic [SUB_W-1:0]   held_red, held_green;
   logic [COORD_W-1:0] cur_x, cur_y;

   pixel_type fresh_pixels [$];
   pixel_type pending_pixels [$];
   stim_type  dir_table [$];

   int  errors = 0;
   int  sent = 0;
   bit  steady = 1'b0;
   bit  choke_req = 1'b0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Truncated mean of three samples.
   function automatic logic [SUB_W-1:0] mean3(input logic [SUB_W-1:0] a,
                                              input logic [SUB_W-1:0] b,
                                              input logic [SUB_W-1:0] c);
      int total;
      total = int'(a) + int'(b) + int'(c);
      return 8'(total / 3);
   endfunction

   // Collect smoothed values into red, green, blue and emit a packed pixel on blue.
   task automatic assemble_pixel(input logic [SUB_W-1:0] v, input bit last);
      pixel_type p;
      case (phase)
         ssr_pkg::PHASE_GREEN: begin
            held_green = v;
            phase = ssr_pkg::PHASE_BLUE;
         end
         ssr_pkg::PHASE_BLUE: begin
            p.pix_x    = cur_x;
            p.pix_y    = cur_y;
            p.color565 = {held_red[7:3], held_green[7:2], v[7:3]};
            p.pix_last = last;
            fresh_pixels.push_back(p);
            cur_x = cur_x + 1'b1;
            phase = ssr_pkg::PHASE_RED;
         end
         default: begin
            held_red = v;
            phase = ssr_pkg::PHASE_GREEN;
         end
      endcase
   endtask

   // Second box filter, fed with first-filter output number idx (saturated).
   task automatic second_filter(input int idx, input logic [SUB_W-1:0] s,
                                input bit row_end, input bit last);
      logic [SUB_W-1:0] p1, p2;
      p1 = smooth_h0;
      p2 = smooth_h1;
      if (idx >= 1)
         assemble_pixel(mean3((idx == 1) ? p1 : p2, p1, s), last);
      // At the row end the right edge is replicated to flush the filter.
      if (row_end) begin
         if (idx == 0)
            assemble_pixel(s, last);
         else
            assemble_pixel(mean3(p1, s, s), last);
      end
      smooth_h1 = p1;
      smooth_h0 = s;
   endtask

   // Expected pixels for one accepted request, appended to fresh_pixels.
   task automatic predict_subpixel(input stim_type st);
      int               k;
      logic [SUB_W-1:0] r1, r2;
      k  = row_pos;
      r1 = raw_h0;
      r2 = raw_h1;
      if (k == 0) begin
         cur_x = st.row_x;
         cur_y = st.row_y;
      end
      if (k >= 1)
         second_filter(k - 1, mean3((k == 1) ? r1 : r2, r1, st.subpixel), 1'b0,
                       st.row_last);
      if (st.row_last)
         second_filter(k, (k == 0) ? st.subpixel : mean3(r1, st.subpixel, st.subpixel),
                       1'b1, st.row_last);
      raw_h1 = r1;
      raw_h0 = st.subpixel;
      // A row end drops any partial group and starts the next row afresh.
      if (st.row_last) begin
         row_pos = 0;
         phase = ssr_pkg::PHASE_RED;
      end else if (k < 3) begin
         row_pos = k + 1;
      end
   endtask

   function automatic stim_type stim_row(input logic [SUB_W-1:0] sub, input int x,
                                         input int y, input bit last,
                                         input check_kind_type kind,
                                         input int px, input int py, input int color,
                                         input bit plast);
      stim_type st;
      st.subpixel      = sub;
      st.row_x         = x[COORD_W-1:0];
      st.row_y         = y[COORD_W-1:0];
      st.row_last      = last;
      st.kind          = kind;
      st.pix.pix_x     = px[COORD_W-1:0];
      st.pix.pix_y     = py[COORD_W-1:0];
      st.pix.color565  = color[COLOR_W-1:0];
      st.pix.pix_last  = plast;
      return st;
   endfunction

   // Mostly back-to-back, sometimes a short pause, now and then a long one.
   function automatic int pick_gap();
      int roll;
      if (steady)
         return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60)
         return 0;
      if (roll < 93)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Offer one request, wait for its acceptance, then record what it should produce.
   task automatic offer(input stim_type st, input bit close);
      int gap;
      req_bus.valid    <= 1'b1;
      req_bus.subpixel <= st.subpixel;
      req_bus.row_x    <= st.row_x;
      req_bus.row_y    <= st.row_y;
      req_bus.row_last <= st.row_last;
      do @(posedge clock); while (!req_bus.ready);
      predict_subpixel(st);
      case (st.kind)
         CHECK_PIXEL: pending_pixels.push_back(st.pix);
         CHECK_NONE: ;
         default: begin
            foreach (fresh_pixels[i])
               pending_pixels.push_back(fresh_pixels[i]);
         end
      endcase
      fresh_pixels.delete();
      sent++;
      gap = pick_gap();
      if (close && gap == 0)
         gap = 1;
      // While idle the payload carries junk that the block must ignore.
      if (gap > 0) begin
         req_bus.valid    <= 1'b0;
         req_bus.subpixel <= 8'($urandom);
         req_bus.row_x    <= 10'($urandom);
         req_bus.row_y    <= 10'($urandom);
         req_bus.row_last <= 1'($urandom);
         repeat (gap) @(posedge clock);
      end
   endtask

   // Receiver: random stalls, no stalls while steady, and one long hold-off on request.
   initial begin
      int hold;
      int roll;
      hold = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (choke_req) begin
            hold = CHOKE_CYCLES;
            choke_req = 1'b0;
         end else if (hold == 0 && !steady) begin
            roll = $urandom_range(0, 99);
            if (roll >= 97)
               hold = $urandom_range(10, 40);
            else if (roll >= 72)
               hold = $urandom_range(1, 3);
         end
         if (hold > 0) begin
            rsp_bus.ready <= 1'b0;
            hold--;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Compare each accepted pixel with the oldest expectation.
   always @(posedge clock) begin : check_pixel
      pixel_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_pixels.size() == 0) begin
            errors++;
            if (errors < REPORT_CAP)
               $display("%0t: unexpected pixel x=%0d y=%0d color=%04h last=%0b", $time,
                        rsp_bus.pix_x, rsp_bus.pix_y, rsp_bus.color565, rsp_bus.pix_last);
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_bus.pix_x !== want.pix_x) begin
               errors++;
               if (errors < REPORT_CAP)
                  $display("%0t: pix_x expected %0d, got %0d", $time, want.pix_x,
                           rsp_bus.pix_x);
            end
            if (rsp_bus.pix_y !== want.pix_y) begin
               errors++;
               if (errors < REPORT_CAP)
                  $display("%0t: pix_y expected %0d, got %0d", $time, want.pix_y,
                           rsp_bus.pix_y);
            end
            if (rsp_bus.color565 !== want.color565) begin
               errors++;
               if (errors < REPORT_CAP)
                  $display("%0t: color565 expected %04h, got %04h", $time, want.color565,
                           rsp_bus.color565);
            end
            if (rsp_bus.pix_last !== want.pix_last) begin
               errors++;
               if (errors < REPORT_CAP)
                  $display("%0t: pix_last expected %0b, got %0b", $time, want.pix_last,
                           rsp_bus.pix_last);
            end
         end
      end
   end

   // Watchdog: end the run if no request and no pixel moves for too long.
   initial begin
      int idle;
      idle = 0;
      while (idle < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            idle = 0;
         else
            idle++;
      end
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Main sequence: reset, directed rows, then random rows.
   initial begin
      int       len;
      int       style;
      int       level;
      int       x, y;
      int       roll;
      bit       last_row;
      bit       pause_row;
      bit       choke_row;
      bit       drained;
      bit       choked;
      stim_type st;

      drained = 1'b0;
      choked  = 1'b0;
      reset            <= 1'b1;
      req_bus.valid    <= 1'b0;
      req_bus.subpixel <= '0;
      req_bus.row_x    <= '0;
      req_bus.row_y    <= '0;
      req_bus.row_last <= 1'b0;

      raw_h0 = '0;
      raw_h1 = '0;
      smooth_h0 = '0;
      smooth_h1 = '0;
      row_pos = 0;
      phase = ssr_pkg::PHASE_RED;
      held_red = '0;
      held_green = '0;
      cur_x = '0;
      cur_y = '0;

      // All-white row of three at the far corner: one white pixel.
      dir_table.push_back(stim_row(8'hFF, 1023, 1023, 0, CHECK_NONE, 0, 0, 0, 0));
      dir_table.push_back(stim_row(8'hFF, 17, 400, 0, CHECK_NONE, 0, 0, 0, 0));
      dir_table.push_back(stim_row(8'hFF, 3, 800, 1, CHECK_PIXEL, 1023, 1023, 16'hFFFF, 1));
      // A one-item row and a two-item row complete no group.
      dir_table.push_back(stim_row(8'hAA, 5, 6, 1, CHECK_NONE, 0, 0, 0, 0));
      dir_table.push_back(stim_row(8'h55, 9, 9, 0, CHECK_NONE, 0, 0, 0, 0));
      dir_table.push_back(stim_row(8'hFF, 9, 9, 1, CHECK_NONE, 0, 0, 0, 0));
      // Six black items starting at the right edge: the second pixel wraps to x 0.
      dir_table.push_back(stim_row(8'h00, 1023, 0, 0, CHECK_NONE, 0, 0, 0, 0));
      dir_table.push_back(stim_row(8'h00, 682, 341, 0, CHECK_NONE, 0, 0, 0, 0));
      dir_table.push_back(stim_row(8'h00, 341, 682, 0, CHECK_NONE, 0, 0, 0, 0));
      dir_table.push_back(stim_row(8'h00, 1023, 1023, 0, CHECK_NONE, 0, 0, 0, 0));
      dir_table.push_back(stim_row(8'h00, 512, 512, 0, CHECK_PIXEL, 1023, 0, 16'h0000, 0));
      dir_table.push_back(stim_row(8'h00, 1, 1, 1, CHECK_PIXEL, 0, 0, 16'h0000, 1));
      // Alternating row of four: one pixel, the trailing value is dropped.
      dir_table.push_back(stim_row(8'h00, 300, 512, 0, CHECK_MODEL, 0, 0, 0, 0));
      dir_table.push_back(stim_row(8'hFF, 1, 2, 0, CHECK_MODEL, 0, 0, 0, 0));
      dir_table.push_back(stim_row(8'h00, 1000, 20, 0, CHECK_MODEL, 0, 0, 0, 0));
      dir_table.push_back(stim_row(8'hFF, 44, 55, 1, CHECK_MODEL, 0, 0, 0, 0));
      // Mixed levels over seven items: two pixels, one value left over.
      dir_table.push_back(stim_row(8'hFF, 640, 333, 0, CHECK_MODEL, 0, 0, 0, 0));
      dir_table.push_back(stim_row(8'h00, 7, 7, 0, CHECK_MODEL, 0, 0, 0, 0));
      dir_table.push_back(stim_row(8'h80, 7, 7, 0, CHECK_MODEL, 0, 0, 0, 0));
      dir_table.push_back(stim_row(8'h01, 7, 7, 0, CHECK_MODEL, 0, 0, 0, 0));
      dir_table.push_back(stim_row(8'hFE, 7, 7, 0, CHECK_MODEL, 0, 0, 0, 0));
      dir_table.push_back(stim_row(8'h7F, 7, 7, 0, CHECK_MODEL, 0, 0, 0, 0));
      dir_table.push_back(stim_row(8'h40, 7, 7, 1, CHECK_MODEL, 0, 0, 0, 0));

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_table[i])
         offer(dir_table[i], i == dir_table.size() - 1);
      wait (pending_pixels.size() == 0);

      // Random rows until the request count is reached.
      while (sent < ITEM_TARGET) begin
         roll = $urandom_range(0, 99);
         if (roll < 8)
            len = $urandom_range(1, 2);
         else if (roll < 68)
            len = $urandom_range(3, 12);
         else if (roll < 93)
            len = $urandom_range(13, 40);
         else
            len = $urandom_range(41, 90);
         style = $urandom_range(0, 3);

         // Once, hold the receiver off while a long row streams in back to back.
         choke_row = !choked && sent >= CHOKE_POINT;
         if (choke_row) begin
            choked = 1'b1;
            len = 80;
            style = 0;
            choke_req = 1'b1;
         end
         steady = choke_row || ($urandom_range(0, 9) == 0);

         last_row  = (sent + len >= ITEM_TARGET);
         pause_row = !drained && (sent + len >= DRAIN_POINT);

         x = ($urandom_range(0, 4) == 0) ? $urandom_range(1018, 1023) : $urandom_range(0, 1023);
         y = $urandom_range(0, 1023);
         level = $urandom_range(0, 255);
         for (int n = 0; n < len; n++) begin
            case (style)
               0: st.subpixel = 8'($urandom_range(0, 255));
               1: st.subpixel = $urandom_range(0, 1) ? 8'hFF : 8'h00;
               2: begin
                  level += int'($urandom_range(0, 16)) - 8;
                  if (level < 0)
                     level = 0;
                  if (level > 255)
                     level = 255;
                  st.subpixel = 8'(level);
               end
               default: st.subpixel = 8'(level);
            endcase
            // Coordinates matter only on the first request of a row.
            st.row_x    = (n == 0) ? 10'(x) : 10'($urandom);
            st.row_y    = (n == 0) ? 10'(y) : 10'($urandom);
            st.row_last = (n == len - 1);
            st.kind     = CHECK_MODEL;
            st.pix      = '0;
            offer(st, (n == len - 1) && (last_row || pause_row));
         end

         // Once, let every expected pixel drain before going on.
         if (pause_row && !last_row) begin
            drained = 1'b1;
            wait (pending_pixels.size() == 0);
         end
      end
      steady = 1'b0;

      wait (pending_pixels.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0 && pending_pixels.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
